// ===== rtl/core/sdff_pkg.sv =====
`timescale 1ns / 1ps

package sdff_pkg;

  // magnitude and decimal digit store
  localparam int MAG_W       = 64;
  localparam int NUM_DIGITS  = 19;
  localparam int DIG_W       = $clog2(NUM_DIGITS + 1);
  localparam int MODE_BITS_W = 7;

  // default field limit
  localparam int DEF_MAX_FIELD_CHARS = 64;

  // ascii codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // operand size codes
  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  // formatter sequencer; emit phases stay in field order
  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_PLAN,
    S_LPAD,
    S_SIGN,
    S_ZERO,
    S_DIGIT,
    S_RPAD
  } fmt_state_t;

  // converter status toward the sequencer
  typedef struct packed {
    logic             done;
    logic [DIG_W-1:0] ndig;
  } cvt_stat_t;

endpackage

// ===== rtl/core/sdff_bcd.sv =====
`timescale 1ns / 1ps

module sdff_bcd
  import sdff_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [MAG_W-1:0]       mag_in,
  input  logic [MODE_BITS_W-1:0] nbits,
  input  logic [DIG_W-1:0]       rd_idx,
  output logic [3:0]             rd_digit,
  output cvt_stat_t              stat
);

  logic [MAG_W-1:0]       sr;
  logic [MODE_BITS_W-1:0] bits_left;
  logic                   busy;
  logic                   done;
  logic [3:0]             bcd [NUM_DIGITS];
  logic [3:0]             adj [NUM_DIGITS];
  logic [3:0]             bcd_next [NUM_DIGITS];
  logic [DIG_W-1:0]       ndig;
  logic                   grow;

  // add-3 correction on every digit, then shift one bit in
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? (bcd[i] + 4'd3) : bcd[i];
    end
    bcd_next[0] = {adj[0][2:0], sr[MAG_W-1]};
    for (int i = 1; i < NUM_DIGITS; i++) begin
      bcd_next[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  // the value at most gains one digit per doubling
  assign grow = (ndig < DIG_W'(NUM_DIGITS)) ? (bcd_next[ndig] != 4'd0) : 1'b0;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bits_left == MODE_BITS_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // bit-serial datapath
  always_ff @(posedge clk) begin
    if (start) begin
      sr        <= mag_in;
      bits_left <= nbits;
      ndig      <= '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        bcd[i] <= 4'd0;
      end
    end else if (busy) begin
      sr        <= {sr[MAG_W-2:0], 1'b0};
      bits_left <= bits_left - MODE_BITS_W'(1);
      ndig      <= ndig + DIG_W'(grow);
      for (int i = 0; i < NUM_DIGITS; i++) begin
        bcd[i] <= bcd_next[i];
      end
    end
  end

  assign rd_digit  = bcd[rd_idx];
  assign stat.done = done;
  assign stat.ndig = ndig;

endmodule

// ===== rtl/core/signed_decimal_field_formatter.sv =====
`timescale 1ns / 1ps

// channel | handshake            | payload
// input   | in_valid / in_ready  | value, size_mode, force_plus, space_sign, zero_fill,
//         |                      | left_align, min_width, min_digits
// output  | out_valid / out_ready| out_char, last
//
// one item at a time: accept in S_IDLE, bit-serial binary to decimal conversion of
// 8/16/32/64 operand bits (by size_mode) in S_CONV until the converter reports done,
// planning in S_PLAN, then one character per cycle while the output is not stalled.
// the output register keeps the last word while the next item is accepted and converted.
// output stalls hold the character sequencer; conversion runs on regardless.
// rst is synchronous and clears the sequencer, the converter control and out_valid.

module signed_decimal_field_formatter
  import sdff_pkg::*;
#(
  parameter int MAX_FIELD_CHARS = DEF_MAX_FIELD_CHARS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [63:0] value,
  input  logic [1:0]        size_mode,
  input  logic              force_plus,
  input  logic              space_sign,
  input  logic              zero_fill,
  input  logic              left_align,
  input  logic [6:0]        min_width,
  input  logic signed [6:0] min_digits,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_char,
  output logic              last
);

  localparam int CNT_W = $clog2(MAX_FIELD_CHARS + 1);

  fmt_state_t state, state_next;

  logic                   accept;
  logic                   can_emit;
  logic                   emit;
  logic [7:0]             emit_char;

  // captured item settings
  logic [CNT_W-1:0]       width_r;
  logic [CNT_W-1:0]       prec_r;
  logic                   has_prec_r;
  logic                   zfill_r;
  logic                   left_r;
  logic                   sign_on;
  logic [7:0]             sign_char;

  // phase counters
  logic [CNT_W-1:0]       pad_cnt;
  logic [CNT_W-1:0]       zero_cnt;
  logic [DIG_W-1:0]       dig_cnt;

  // input side
  logic [MAG_W-1:0]       ext_val;
  logic [MAG_W-1:0]       mag;
  logic [MAG_W-1:0]       mag_aligned;
  logic [MODE_BITS_W-1:0] nbits;
  logic                   in_has_prec;
  logic [CNT_W-1:0]       in_width;
  logic [CNT_W-1:0]       in_prec;

  // plan
  logic [DIG_W-1:0]       plan_digs;
  logic [CNT_W-1:0]       plan_digs_w;
  logic [CNT_W-1:0]       plan_zeros0;
  logic [CNT_W-1:0]       plan_content;
  logic [CNT_W-1:0]       plan_pad0;
  logic                   plan_zmode;
  logic [CNT_W-1:0]       plan_pad;
  logic [CNT_W-1:0]       plan_zeros;

  cvt_stat_t              cvt_stat;
  logic [3:0]             cur_digit;

  // first non-empty phase at or after from
  function automatic fmt_state_t pick(
    input fmt_state_t       from,
    input logic             left,
    input logic [CNT_W-1:0] pad,
    input logic             sgn,
    input logic [CNT_W-1:0] zeros,
    input logic [DIG_W-1:0] digs
  );
    fmt_state_t res;
    res = S_IDLE;
    if (left && pad != '0) res = S_RPAD;
    if (from <= S_DIGIT && digs != '0) res = S_DIGIT;
    if (from <= S_ZERO && zeros != '0) res = S_ZERO;
    if (from <= S_SIGN && sgn) res = S_SIGN;
    if (from <= S_LPAD && !left && pad != '0) res = S_LPAD;
    return res;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign can_emit = !out_valid || out_ready;

  // truncate, sign-extend and take the magnitude
  always_comb begin
    case (size_mode)
      SIZE_8:  ext_val = {{56{value[7]}}, value[7:0]};
      SIZE_16: ext_val = {{48{value[15]}}, value[15:0]};
      SIZE_32: ext_val = {{32{value[31]}}, value[31:0]};
      default: ext_val = value;
    endcase
    mag = ext_val[MAG_W-1] ? (~ext_val + 64'd1) : ext_val;
    case (size_mode)
      SIZE_8: begin
        mag_aligned = {mag[7:0], 56'd0};
        nbits       = 7'd8;
      end
      SIZE_16: begin
        mag_aligned = {mag[15:0], 48'd0};
        nbits       = 7'd16;
      end
      SIZE_32: begin
        mag_aligned = {mag[31:0], 32'd0};
        nbits       = 7'd32;
      end
      default: begin
        mag_aligned = mag;
        nbits       = 7'd64;
      end
    endcase
  end

  // clamp width and precision
  always_comb begin
    in_has_prec = !min_digits[6];
    in_width = (int'(min_width) > MAX_FIELD_CHARS) ? CNT_W'(MAX_FIELD_CHARS)
                                                   : min_width[CNT_W-1:0];
    if (!in_has_prec) begin
      in_prec = CNT_W'(1);
    end else if (int'(min_digits[5:0]) > MAX_FIELD_CHARS - 1) begin
      in_prec = CNT_W'(MAX_FIELD_CHARS - 1);
    end else begin
      in_prec = min_digits[CNT_W-1:0];
    end
  end

  // capture the item
  always_ff @(posedge clk) begin
    if (accept) begin
      width_r    <= in_width;
      prec_r     <= in_prec;
      has_prec_r <= in_has_prec;
      zfill_r    <= zero_fill;
      left_r     <= left_align;
      sign_on    <= ext_val[MAG_W-1] || force_plus || space_sign;
      if (ext_val[MAG_W-1]) begin
        sign_char <= CH_MINUS;
      end else if (force_plus) begin
        sign_char <= CH_PLUS;
      end else begin
        sign_char <= CH_SPACE;
      end
    end
  end

  sdff_bcd u_bcd (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .mag_in   (mag_aligned),
    .nbits    (nbits),
    .rd_idx   (dig_cnt - DIG_W'(1)),
    .rd_digit (cur_digit),
    .stat     (cvt_stat)
  );

  // field layout once the digit count is known
  always_comb begin
    if (cvt_stat.ndig == '0) begin
      plan_digs = (has_prec_r && prec_r == '0) ? DIG_W'(0) : DIG_W'(1);
    end else begin
      plan_digs = cvt_stat.ndig;
    end
    plan_digs_w  = CNT_W'(plan_digs);
    plan_zeros0  = (prec_r > plan_digs_w) ? (prec_r - plan_digs_w) : '0;
    plan_content = CNT_W'(sign_on) + plan_zeros0 + plan_digs_w;
    plan_pad0    = (width_r > plan_content) ? (width_r - plan_content) : '0;
    plan_zmode   = zfill_r && !left_r && !has_prec_r;
    plan_pad     = plan_zmode ? '0 : plan_pad0;
    plan_zeros   = plan_zmode ? (plan_zeros0 + plan_pad0) : plan_zeros0;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CONV;
      end
      S_CONV: begin
        if (cvt_stat.done) state_next = S_PLAN;
      end
      S_PLAN: begin
        state_next = pick(S_LPAD, left_r, plan_pad, sign_on, plan_zeros, plan_digs);
      end
      S_LPAD: begin
        if (can_emit && pad_cnt == CNT_W'(1)) begin
          state_next = pick(S_SIGN, left_r, pad_cnt, sign_on, zero_cnt, dig_cnt);
        end
      end
      S_SIGN: begin
        if (can_emit) state_next = pick(S_ZERO, left_r, pad_cnt, sign_on, zero_cnt, dig_cnt);
      end
      S_ZERO: begin
        if (can_emit && zero_cnt == CNT_W'(1)) begin
          state_next = pick(S_DIGIT, left_r, pad_cnt, sign_on, zero_cnt, dig_cnt);
        end
      end
      S_DIGIT: begin
        if (can_emit && dig_cnt == DIG_W'(1)) begin
          state_next = pick(S_RPAD, left_r, pad_cnt, sign_on, zero_cnt, dig_cnt);
        end
      end
      S_RPAD: begin
        if (can_emit && pad_cnt == CNT_W'(1)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // character for the current phase
  always_comb begin
    emit      = 1'b0;
    emit_char = CH_SPACE;
    unique case (state) inside
      S_LPAD, S_RPAD: begin
        emit      = can_emit;
        emit_char = CH_SPACE;
      end
      S_SIGN: begin
        emit      = can_emit;
        emit_char = sign_char;
      end
      S_ZERO: begin
        emit      = can_emit;
        emit_char = CH_ZERO;
      end
      S_DIGIT: begin
        emit      = can_emit;
        emit_char = {CH_ZERO[7:4], cur_digit};
      end
      default: begin
        emit      = 1'b0;
        emit_char = CH_SPACE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // phase counters
  always_ff @(posedge clk) begin
    if (state == S_PLAN) begin
      pad_cnt  <= plan_pad;
      zero_cnt <= plan_zeros;
      dig_cnt  <= plan_digs;
    end else if (emit) begin
      if (state == S_LPAD || state == S_RPAD) pad_cnt <= pad_cnt - CNT_W'(1);
      if (state == S_ZERO) zero_cnt <= zero_cnt - CNT_W'(1);
      if (state == S_DIGIT) dig_cnt <= dig_cnt - DIG_W'(1);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= emit_char;
      last     <= (state_next == S_IDLE);
    end
  end

endmodule

// ===== rtl/core/sdff_checker.sv =====
`timescale 1ns / 1ps

module sdff_checker
  import sdff_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic signed [63:0] value,
  input logic [1:0]        size_mode,
  input logic              force_plus,
  input logic              space_sign,
  input logic              zero_fill,
  input logic              left_align,
  input logic [6:0]        min_width,
  input logic signed [6:0] min_digits,
  input logic              out_valid,
  input logic              out_ready,
  input logic [7:0]        out_char,
  input logic              last
);

  // a waiting input word keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(value) && $stable(size_mode) &&
      $stable(force_plus) && $stable(space_sign) && $stable(zero_fill) &&
      $stable(left_align) && $stable(min_width) && $stable(min_digits))
    else $error("input word changed while waiting");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last))
    else $error("output word changed while stalled");

  // conversion keeps the input closed after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input reopened during conversion");

  // only sign, space and decimal digit characters leave the block
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_char == CH_SPACE) || (out_char == CH_PLUS) ||
                  (out_char == CH_MINUS) ||
                  ((out_char >= CH_ZERO) && (out_char <= CH_ZERO + 8'd9)))
    else $error("unexpected output character");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word survived reset");

endmodule

bind signed_decimal_field_formatter sdff_checker u_sdff_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .value      (value),
  .size_mode  (size_mode),
  .force_plus (force_plus),
  .space_sign (space_sign),
  .zero_fill  (zero_fill),
  .left_align (left_align),
  .min_width  (min_width),
  .min_digits (min_digits),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_char   (out_char),
  .last       (last)
);

// ===== verif/tb_signed_decimal_field_formatter.sv =====
`timescale 1ns / 1ps

module tb_signed_decimal_field_formatter
  import sdff_pkg::*;
;

  localparam int FIELD_MAX = DEF_MAX_FIELD_CHARS;
  localparam int CYCLE_LIMIT = 1500000;
  // accept + widest conversion + finish + planning + longest field, twice over
  localparam int SETTLE_CYCLES = 2 * (3 + 64 + FIELD_MAX);
  localparam logic [6:0] NO_PREC = 7'h7F;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  // expected characters of every accepted field, in output order
  class field_scoreboard;
    char_word_t pending_chars[$];
    int errors;
    int items;
    int chars_seen;
    int empty_items;

    task report_mismatch(string what);
      if (errors < 30) $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    // %d conversion of one input word into its field characters
    function void note_item(logic [63:0] raw, logic [1:0] sz, bit plus, bit space,
                            bit zfill, bit left, logic [6:0] wid, logic [6:0] prc);
      logic [63:0] ext;
      logic [63:0] mag;
      logic [7:0] digits[$];
      logic [7:0] field[$];
      logic [7:0] sign_ch;
      bit neg;
      bit has_prec;
      bit has_sign;
      int width;
      int prec;
      int zeros;
      int content;
      int pad;
      case (sz)
        SIZE_8:  ext = {{56{raw[7]}}, raw[7:0]};
        SIZE_16: ext = {{48{raw[15]}}, raw[15:0]};
        SIZE_32: ext = {{32{raw[31]}}, raw[31:0]};
        default: ext = raw;
      endcase
      neg = ext[63];
      mag = neg ? (~ext + 64'd1) : ext;
      // any negative precision means none given
      has_prec = !prc[6];
      prec = has_prec ? int'(prc) : 1;
      width = (int'(wid) > FIELD_MAX) ? FIELD_MAX : int'(wid);
      if (prec > FIELD_MAX - 1) prec = FIELD_MAX - 1;
      has_sign = neg || plus || space;
      sign_ch = neg ? CH_MINUS : (plus ? CH_PLUS : CH_SPACE);
      // zero at precision zero prints no digits
      if (!(mag == 64'd0 && has_prec && prec == 0)) begin
        do begin
          digits.push_front(CH_ZERO + 8'(mag % 64'd10));
          mag = mag / 64'd10;
        end while (mag != 64'd0);
      end
      zeros = (prec > digits.size()) ? prec - digits.size() : 0;
      content = int'(has_sign) + zeros + digits.size();
      pad = (width > content) ? width - content : 0;
      if (zfill && !left && !has_prec) begin
        zeros += pad;
        pad = 0;
      end
      if (!left) repeat (pad) field.push_back(CH_SPACE);
      if (has_sign) field.push_back(sign_ch);
      repeat (zeros) field.push_back(CH_ZERO);
      foreach (digits[k]) field.push_back(digits[k]);
      if (left) repeat (pad) field.push_back(CH_SPACE);
      foreach (field[k])
        pending_chars.push_back('{ch: field[k], last: (k == field.size() - 1)});
      items++;
      if (field.size() == 0) empty_items++;
    endfunction

    // compare one output word with the oldest expected character
    task check_char(logic [7:0] ch, logic lst);
      char_word_t want;
      chars_seen++;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected word char=%02h last=%b", ch, lst));
        return;
      end
      want = pending_chars.pop_front();
      if (ch !== want.ch)
        report_mismatch($sformatf("char %02h, expected %02h", ch, want.ch));
      if (lst !== want.last)
        report_mismatch($sformatf("last %b, expected %b (char %02h)", lst, want.last,
                                  want.ch));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [63:0] value = '0;
  logic [1:0] size_mode = SIZE_64;
  logic force_plus = 1'b0;
  logic space_sign = 1'b0;
  logic zero_fill = 1'b0;
  logic left_align = 1'b0;
  logic [6:0] min_width = '0;
  logic signed [6:0] min_digits = NO_PREC;
  logic out_valid;
  logic out_ready = 1'b1;
  logic [7:0] out_char;
  logic last;

  field_scoreboard sb;
  int cycles = 0;
  int stall_pct = 0;
  int gap_pct = 0;

  signed_decimal_field_formatter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .size_mode (size_mode),
    .force_plus(force_plus),
    .space_sign(space_sign),
    .zero_fill (zero_fill),
    .left_align(left_align),
    .min_width (min_width),
    .min_digits(min_digits),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last      (last)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_signed_decimal_field_formatter failed");
      $finish;
    end
  end

  // output word monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_char(out_char, last);
  end

  // receiver stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // present one input word and hold it until accepted
  task automatic send_item(input logic [63:0] v, input logic [1:0] sz, input bit plus,
                           input bit space, input bit zfill, input bit left,
                           input logic [6:0] wid, input logic [6:0] prc);
    in_valid   <= 1'b1;
    value      <= v;
    size_mode  <= sz;
    force_plus <= plus;
    space_sign <= space;
    zero_fill  <= zfill;
    left_align <= left;
    min_width  <= wid;
    min_digits <= prc;
    do begin
      @(posedge clk);
    end while (!in_ready);
    sb.note_item(v, sz, plus, space, zfill, left, wid, prc);
  endtask

  // sender idle burst
  task automatic maybe_gap();
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // drop valid and wait until every expected character has come out
  task automatic drain_output();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (sb.pending_chars.size() != 0);
  endtask

  task automatic send_random_item();
    logic [63:0] v;
    logic [1:0] sz;
    logic [6:0] wid;
    logic [6:0] prc;
    longint near_zero;
    int bits;
    sz = 2'($urandom_range(0, 3));
    bits = 8 << sz;
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: begin
        near_zero = longint'($urandom_range(0, 2000));
        v = near_zero - 1000;
      end
      2: v = 64'd0;
      3: begin
        // edges of the selected operand size
        case ($urandom_range(0, 3))
          0: v = 64'd1 << (bits - 1);
          1: v = (64'd1 << (bits - 1)) - 64'd1;
          2: v = '1;
          default: v = (64'd1 << (bits - 1)) + 64'd1;
        endcase
      end
      4: begin
        v = 64'd1;
        repeat ($urandom_range(0, 18)) v = v * 64'd10;
        v = v - 64'($urandom_range(0, 1));
        if ($urandom_range(0, 1)) v = ~v + 64'd1;
      end
      default: v = {{32{1'b0}}, $urandom} - 64'h8000_0000;
    endcase
    if ($urandom_range(0, 9) == 0) wid = 7'($urandom_range(0, 127));
    else wid = 7'($urandom_range(0, 22));
    case ($urandom_range(0, 9)) inside
      [0:3]: prc = NO_PREC;
      4: prc = 7'($urandom_range(64, 127));
      5: prc = 7'd0;
      9: prc = 7'($urandom_range(0, 63));
      default: prc = 7'($urandom_range(0, 20));
    endcase
    send_item(v, sz, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), wid, prc);
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed fields: zero cases, size edges, flag combinations, clamping
    send_item(64'd0, SIZE_64, 0, 0, 0, 0, 7'd0, NO_PREC);
    send_item(64'd0, SIZE_64, 0, 0, 0, 0, 7'd0, 7'd0);
    send_item(64'd0, SIZE_32, 0, 0, 0, 0, 7'd5, 7'd0);
    send_item(64'd0, SIZE_16, 1, 0, 0, 0, 7'd0, 7'd0);
    send_item(64'h8000_0000_0000_0000, SIZE_64, 0, 0, 0, 0, 7'd0, NO_PREC);
    send_item(64'h7FFF_FFFF_FFFF_FFFF, SIZE_64, 1, 0, 0, 0, 7'd0, NO_PREC);
    send_item(64'h0000_0000_0000_0080, SIZE_8, 0, 0, 0, 0, 7'd0, NO_PREC);
    send_item(64'hFFFF_FFFF_FFFF_FF7F, SIZE_8, 0, 0, 0, 0, 7'd0, NO_PREC);
    send_item(64'h0000_0000_0000_8000, SIZE_16, 0, 0, 0, 0, 7'd0, NO_PREC);
    send_item(64'h1234_5678_8000_0000, SIZE_32, 0, 0, 0, 0, 7'd0, NO_PREC);
    send_item(64'd42, SIZE_32, 0, 1, 0, 0, 7'd0, NO_PREC);
    send_item(64'd42, SIZE_32, 1, 1, 0, 0, 7'd0, NO_PREC);
    send_item(-64'sd42, SIZE_64, 1, 1, 1, 0, 7'd10, NO_PREC);
    send_item(64'd42, SIZE_64, 0, 0, 1, 0, 7'd10, 7'd5);
    send_item(64'd42, SIZE_64, 0, 0, 1, 1, 7'd8, NO_PREC);
    send_item(64'd7, SIZE_8, 0, 0, 0, 0, 7'd0, 7'd63);
    send_item(64'hFFFF_FFFF_FFFF_FFFF, SIZE_64, 0, 0, 0, 0, 7'd64, 7'd63);
    send_item(64'd1, SIZE_64, 0, 0, 0, 1, 7'd64, NO_PREC);
    send_item(64'd1, SIZE_64, 0, 0, 0, 0, 7'd127, NO_PREC);
    send_item(64'd99, SIZE_16, 0, 0, 0, 0, 7'd6, 7'h40);
    send_item(64'd5, SIZE_8, 0, 1, 1, 0, 7'd6, NO_PREC);
    send_item(64'd0, SIZE_8, 0, 1, 0, 1, 7'd3, 7'd0);
    send_item(64'h8000_0000_0000_0000, SIZE_64, 0, 0, 1, 0, 7'd64, NO_PREC);
    send_item(64'd0, SIZE_64, 0, 0, 1, 0, 7'd4, NO_PREC);

    // random fields with light idling on both sides
    stall_pct = 15;
    gap_pct = 20;
    repeat (110) begin
      maybe_gap();
      send_random_item();
    end

    // hold the sender until the output has caught up
    drain_output();

    // heavier idling
    stall_pct = 40;
    gap_pct = 45;
    repeat (110) begin
      maybe_gap();
      send_random_item();
    end

    // back-to-back words, no idling
    stall_pct = 0;
    gap_pct = 0;
    repeat (80) send_random_item();

    drain_output();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending_chars.size() != 0)
      sb.report_mismatch($sformatf("%0d characters never came", sb.pending_chars.size()));

    $display("covered %0d fields (%0d with no characters), %0d characters checked",
             sb.items, sb.empty_items, sb.chars_seen);
    $display("all operand sizes, sign flags, padding modes and precision edges, %0d errors",
             sb.errors);
    if (sb.errors == 0) $display("tb_signed_decimal_field_formatter passed");
    else $display("tb_signed_decimal_field_formatter failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sdff_pkg.sv
rtl/core/sdff_bcd.sv
rtl/core/signed_decimal_field_formatter.sv
rtl/core/sdff_checker.sv
verif/tb_signed_decimal_field_formatter.sv
